### rtl/core/uartrb_pkg.sv
`default_nettype none
package uartrb_pkg;

    localparam int RX_DEPTH  = 32;
    localparam int TX_DEPTH  = 32;
    localparam int RX_IDX_W  = $clog2(RX_DEPTH);
    localparam int TX_IDX_W  = $clog2(TX_DEPTH);
    localparam int RX_FILL_W = RX_IDX_W + 1;
    localparam int TX_FILL_W = TX_IDX_W + 1;
    localparam int COUNT_W   = 5;

    localparam logic [7:0] FLAG_BYTE_RESET = 8'd126;

    localparam logic [2:0] REQ_RX_BYTE  = 3'd0;
    localparam logic [2:0] REQ_RX_POP   = 3'd1;
    localparam logic [2:0] REQ_TX_PUSH  = 3'd2;
    localparam logic [2:0] REQ_TX_PULL  = 3'd3;
    localparam logic [2:0] REQ_RX_FLUSH = 3'd4;

    localparam logic [2:0] ERR_NONE     = 3'b000;
    localparam logic [2:0] ERR_FRAME    = 3'b001;
    localparam logic [2:0] ERR_OVERRUN  = 3'b010;
    localparam logic [2:0] ERR_OVERFLOW = 3'b100;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_in;
        logic       frame_error;
        logic       data_overrun;
    } uartrb_in_t;

    typedef struct packed {
        logic               out_valid;
        logic [7:0]         out_data;
        logic [2:0]         rx_error;
        logic               flag_seen;
        logic               tx_accepted;
        logic [COUNT_W-1:0] rx_count;
        logic [COUNT_W-1:0] tx_count;
        logic               tx_request;
    } uartrb_out_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } uartrb_cmd_t;

endpackage
`default_nettype wire

### rtl/core/uartrb_ctrl.sv
`default_nettype none
module uartrb_ctrl import uartrb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output uartrb_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides open together");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("result not presented two cycles after input beat");

    a_return_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready)
        else $error("not ready for input after result beat");
`endif

endmodule
`default_nettype wire

### rtl/core/uartrb_dp.sv
`default_nettype none
module uartrb_dp import uartrb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire uartrb_cmd_t cmd,
    input  wire uartrb_in_t  s_data,
    input  wire logic        cfg_wr,
    input  wire logic [7:0]  cfg_data,
    output uartrb_out_t      m_data
);

    uartrb_in_t item_reg;
    logic [7:0] flag_byte_reg;

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_rd_reg;
    logic [7:0] tx_rd_reg;

    logic [RX_IDX_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_IDX_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_IDX_W-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_IDX_W-1:0] tx_head_inc, tx_tail_inc;
    logic [2:0]          last_err_reg, last_err_next;
    logic                tx_pending_reg, tx_pending_next;

    logic       res_valid_reg, res_valid_next;
    logic       res_src_tx_reg, res_src_tx_next;
    logic [2:0] res_err_reg, res_err_next;
    logic       res_flag_reg, res_flag_next;
    logic       res_acc_reg, res_acc_next;

    logic       rx_wr, rx_rd, tx_wr, tx_rd;
    logic [2:0] line_err;

    logic [RX_FILL_W-1:0] rx_fill;
    logic [TX_FILL_W-1:0] tx_fill;

    assign rx_head_inc = (rx_head_reg == RX_IDX_W'(RX_DEPTH - 1)) ? '0
                       : rx_head_reg + RX_IDX_W'(1);
    assign rx_tail_inc = (rx_tail_reg == RX_IDX_W'(RX_DEPTH - 1)) ? '0
                       : rx_tail_reg + RX_IDX_W'(1);
    assign tx_head_inc = (tx_head_reg == TX_IDX_W'(TX_DEPTH - 1)) ? '0
                       : tx_head_reg + TX_IDX_W'(1);
    assign tx_tail_inc = (tx_tail_reg == TX_IDX_W'(TX_DEPTH - 1)) ? '0
                       : tx_tail_reg + TX_IDX_W'(1);

    always_comb begin
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        last_err_next   = last_err_reg;
        tx_pending_next = tx_pending_reg;
        res_valid_next  = res_valid_reg;
        res_src_tx_next = res_src_tx_reg;
        res_err_next    = res_err_reg;
        res_flag_next   = res_flag_reg;
        res_acc_next    = res_acc_reg;
        rx_wr           = 1'b0;
        rx_rd           = 1'b0;
        tx_wr           = 1'b0;
        tx_rd           = 1'b0;
        line_err        = (item_reg.frame_error ? ERR_FRAME : ERR_NONE)
                        | (item_reg.data_overrun ? ERR_OVERRUN : ERR_NONE);
        if (cmd.execute) begin
            res_valid_next  = 1'b0;
            res_src_tx_next = 1'b0;
            res_err_next    = ERR_NONE;
            res_flag_next   = 1'b0;
            res_acc_next    = 1'b0;
            case (item_reg.req_type)
                REQ_RX_BYTE: begin
                    if (rx_head_inc == rx_tail_reg) begin
                        line_err = ERR_OVERFLOW;
                    end else begin
                        rx_head_next = rx_head_inc;
                        rx_wr        = 1'b1;
                    end
                    last_err_next = line_err;
                    res_err_next  = line_err;
                    res_flag_next = (item_reg.data_in == flag_byte_reg);
                end
                REQ_RX_POP: begin
                    if (rx_head_reg != rx_tail_reg) begin
                        rx_tail_next   = rx_tail_inc;
                        rx_rd          = 1'b1;
                        res_valid_next = 1'b1;
                        res_err_next   = last_err_reg;
                    end
                end
                REQ_TX_PUSH: begin
                    if (tx_head_inc != tx_tail_reg) begin
                        tx_head_next = tx_head_inc;
                        tx_wr        = 1'b1;
                        res_acc_next = 1'b1;
                    end
                    tx_pending_next = 1'b1;
                end
                REQ_TX_PULL: begin
                    if (tx_head_reg != tx_tail_reg) begin
                        tx_tail_next    = tx_tail_inc;
                        tx_rd           = 1'b1;
                        res_valid_next  = 1'b1;
                        res_src_tx_next = 1'b1;
                    end else begin
                        tx_pending_next = 1'b0;
                    end
                end
                REQ_RX_FLUSH: begin
                    rx_head_next = rx_tail_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_byte_reg  <= FLAG_BYTE_RESET;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            last_err_reg   <= ERR_NONE;
            tx_pending_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_src_tx_reg <= 1'b0;
            res_err_reg    <= ERR_NONE;
            res_flag_reg   <= 1'b0;
            res_acc_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                flag_byte_reg <= cfg_data;
            end
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            last_err_reg   <= last_err_next;
            tx_pending_reg <= tx_pending_next;
            res_valid_reg  <= res_valid_next;
            res_src_tx_reg <= res_src_tx_next;
            res_err_reg    <= res_err_next;
            res_flag_reg   <= res_flag_next;
            res_acc_reg    <= res_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_wr) begin
            rx_mem[rx_head_inc] <= item_reg.data_in;
        end
        if (rx_rd) begin
            rx_rd_reg <= rx_mem[rx_tail_inc];
        end
    end

    always_ff @(posedge aclk) begin
        if (tx_wr) begin
            tx_mem[tx_head_inc] <= item_reg.data_in;
        end
        if (tx_rd) begin
            tx_rd_reg <= tx_mem[tx_tail_inc];
        end
    end

    always_comb begin
        if (rx_head_reg >= rx_tail_reg) begin
            rx_fill = {1'b0, rx_head_reg} - {1'b0, rx_tail_reg};
        end else begin
            rx_fill = {1'b0, rx_head_reg} + RX_FILL_W'(RX_DEPTH) - {1'b0, rx_tail_reg};
        end
        if (tx_head_reg >= tx_tail_reg) begin
            tx_fill = {1'b0, tx_head_reg} - {1'b0, tx_tail_reg};
        end else begin
            tx_fill = {1'b0, tx_head_reg} + TX_FILL_W'(TX_DEPTH) - {1'b0, tx_tail_reg};
        end
    end

    always_comb begin
        m_data.out_valid   = res_valid_reg;
        m_data.out_data    = !res_valid_reg ? 8'd0 : (res_src_tx_reg ? tx_rd_reg : rx_rd_reg);
        m_data.rx_error    = res_err_reg;
        m_data.flag_seen   = res_flag_reg;
        m_data.tx_accepted = res_acc_reg;
        m_data.rx_count    = COUNT_W'(rx_fill);
        m_data.tx_count    = COUNT_W'(tx_fill);
        m_data.tx_request  = tx_pending_reg;
    end

`ifndef SYNTHESIS
    a_acc_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        res_acc_reg |-> tx_pending_reg)
        else $error("push stored without transmit request");

    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && item_reg.req_type == REQ_RX_FLUSH |=> rx_head_reg == rx_tail_reg)
        else $error("receive ring not empty after flush");

    a_overflow_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && item_reg.req_type == REQ_RX_BYTE && rx_head_inc == rx_tail_reg
        |=> last_err_reg == ERR_OVERFLOW && $stable(rx_head_reg))
        else $error("full receive ring took a byte");
`endif

endmodule
`default_nettype wire

### rtl/core/uart_ring_buffer_pair.sv
// The result beat is presented in the respond state, after accept and execute.
// A new input beat is accepted only after the previous result beat is taken; the
// controller steps accept, execute and present around the registered ring read.
// Reset: synchronous, active low; both rings empty, latched error and transmit
// request cleared, flag byte 0x7E; ring contents undefined until written.
`default_nettype none
module uart_ring_buffer_pair import uartrb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire uartrb_in_t  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output uartrb_out_t      m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    uartrb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    uartrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    uartrb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

### dv/testbench.sv
module testbench import uartrb_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         PHASE_ITEMS   = 350;
    localparam logic [2:0] REQ_UNUSED_LO = REQ_RX_FLUSH + 3'd1;
    localparam logic [2:0] REQ_UNUSED_HI = '1;

    class ring_pair_tracker;
        logic [7:0]  flag;
        logic [7:0]  rx_ring [RX_DEPTH];
        logic [7:0]  tx_ring [TX_DEPTH];
        int          rx_head, rx_tail, tx_head, tx_tail;
        logic [2:0]  rx_err;
        logic        tx_pending;
        uartrb_out_t due_responses [$];
        int          errors;

        function new();
            flag       = FLAG_BYTE_RESET;
            rx_head    = 0;
            rx_tail    = 0;
            tx_head    = 0;
            tx_tail    = 0;
            rx_err     = ERR_NONE;
            tx_pending = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return due_responses.size();
        endfunction

        function int step_index(int i, int depth);
            return (i + 1 >= depth) ? 0 : i + 1;
        endfunction

        function logic [COUNT_W-1:0] occupancy(int head, int tail, int depth);
            return COUNT_W'((head >= tail) ? head - tail : head + depth - tail);
        endfunction

        function void accept_request(uartrb_in_t it);
            uartrb_out_t r;
            int          nxt;
            r = '0;
            case (it.req_type)
                REQ_RX_BYTE: begin
                    r.rx_error = (it.frame_error ? ERR_FRAME : ERR_NONE) |
                                 (it.data_overrun ? ERR_OVERRUN : ERR_NONE);
                    nxt = step_index(rx_head, RX_DEPTH);
                    if (nxt == rx_tail) begin
                        r.rx_error = ERR_OVERFLOW;
                    end else begin
                        rx_head      = nxt;
                        rx_ring[nxt] = it.data_in;
                    end
                    rx_err      = r.rx_error;
                    r.flag_seen = (it.data_in == flag);
                end
                REQ_RX_POP: begin
                    if (rx_head != rx_tail) begin
                        rx_tail     = step_index(rx_tail, RX_DEPTH);
                        r.out_data  = rx_ring[rx_tail];
                        r.out_valid = 1'b1;
                        r.rx_error  = rx_err;
                    end
                end
                REQ_TX_PUSH: begin
                    nxt = step_index(tx_head, TX_DEPTH);
                    if (nxt != tx_tail) begin
                        tx_ring[nxt]  = it.data_in;
                        tx_head       = nxt;
                        r.tx_accepted = 1'b1;
                    end
                    tx_pending = 1'b1;
                end
                REQ_TX_PULL: begin
                    if (tx_head != tx_tail) begin
                        tx_tail     = step_index(tx_tail, TX_DEPTH);
                        r.out_data  = tx_ring[tx_tail];
                        r.out_valid = 1'b1;
                    end else begin
                        tx_pending = 1'b0;
                    end
                end
                REQ_RX_FLUSH: begin
                    rx_head = rx_tail;
                end
                default: begin
                end
            endcase
            r.rx_count   = occupancy(rx_head, rx_tail, RX_DEPTH);
            r.tx_count   = occupancy(tx_head, tx_tail, TX_DEPTH);
            r.tx_request = tx_pending;
            due_responses.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%s mismatch: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_response(uartrb_out_t got);
            uartrb_out_t want;
            if (due_responses.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("response beat with nothing due: %h", got);
                return;
            end
            want = due_responses.pop_front();
            compare_field("out_valid",   8'(want.out_valid),   8'(got.out_valid));
            compare_field("out_data",    want.out_data,        got.out_data);
            compare_field("rx_error",    8'(want.rx_error),    8'(got.rx_error));
            compare_field("flag_seen",   8'(want.flag_seen),   8'(got.flag_seen));
            compare_field("tx_accepted", 8'(want.tx_accepted), 8'(got.tx_accepted));
            compare_field("rx_count",    8'(want.rx_count),    8'(got.rx_count));
            compare_field("tx_count",    8'(want.tx_count),    8'(got.tx_count));
            compare_field("tx_request",  8'(want.tx_request),  8'(got.tx_request));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    uartrb_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    uartrb_out_t m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int               send_idle;
    int               stall_pct;
    ring_pair_tracker sb;

    always #1 aclk = ~aclk;

    uart_ring_buffer_pair u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic uartrb_in_t make_beat(logic [2:0] kind, logic [7:0] value,
                                             logic fe, logic dor);
        uartrb_in_t it;
        it.req_type     = kind;
        it.data_in      = value;
        it.frame_error  = fe;
        it.data_overrun = dor;
        return it;
    endfunction

    function automatic uartrb_in_t random_request(bit biased, logic [2:0] favourite);
        uartrb_in_t it;
        int         roll;
        roll = $urandom_range(99, 0);
        if (roll < 1)
            it.req_type = REQ_RX_FLUSH;
        else if (roll < 3)
            it.req_type = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        else if (biased && roll < 85)
            it.req_type = favourite;
        else
            it.req_type = 3'($urandom_range(REQ_TX_PULL, REQ_RX_BYTE));
        it.data_in      = ($urandom_range(7, 0) == 0) ? sb.flag : 8'($urandom);
        it.frame_error  = 1'($urandom);
        it.data_overrun = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(uartrb_in_t it);
        while ($urandom_range(99, 0) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.accept_request(it);
    endtask

    task automatic write_flag(logic [7:0] value);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.flag = value;
    endtask

    // bursts lean towards one request kind so the rings reach full and empty
    task automatic run_phase(int items, bit vary_idle);
        int         sent;
        int         len;
        bit         biased;
        logic [2:0] favourite;
        uartrb_in_t it;
        sent = 0;
        while (sent < items) begin
            len       = $urandom_range(48, 1);
            biased    = ($urandom_range(4, 0) != 0);
            favourite = 3'($urandom_range(REQ_TX_PULL, REQ_RX_BYTE));
            if (vary_idle) begin
                case ($urandom_range(3, 0))
                    0: begin
                        send_idle = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        send_idle = 84;
                        stall_pct = 0;
                    end
                    2: begin
                        send_idle = 0;
                        stall_pct = 84;
                    end
                    default: begin
                        send_idle = 23;
                        stall_pct = 23;
                    end
                endcase
            end
            repeat (len) begin
                it = random_request(biased, favourite);
                send_item(it);
                if (it.req_type <= REQ_RX_FLUSH)
                    sent++;
            end
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_response(m_data);
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        sb        = new();
        send_idle = 0;
        stall_pct = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // opening beats with the flag byte at its reset value
        send_item(make_beat(REQ_RX_POP,    8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PULL,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_RX_BYTE,   8'h7E, 1'b1, 1'b0));
        send_item(make_beat(REQ_RX_BYTE,   8'h00, 1'b0, 1'b1));
        send_item(make_beat(REQ_RX_BYTE,   8'hFF, 1'b1, 1'b1));
        send_item(make_beat(REQ_RX_POP,    8'hFF, 1'b1, 1'b1));
        send_item(make_beat(REQ_TX_PUSH,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PUSH,   8'hFF, 1'b1, 1'b1));
        send_item(make_beat(REQ_TX_PUSH,   8'hA5, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PULL,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PULL,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PULL,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_TX_PULL,   8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_RX_FLUSH,  8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_RX_POP,    8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_UNUSED_LO, 8'hFF, 1'b1, 1'b1));
        send_item(make_beat(REQ_UNUSED_HI, 8'h00, 1'b0, 1'b0));
        send_item(make_beat(REQ_RX_BYTE,   8'h81, 1'b0, 1'b0));
        send_item(make_beat(REQ_RX_POP,    8'h00, 1'b0, 1'b0));

        write_flag(8'h00);
        run_phase(PHASE_ITEMS, 1'b0);

        write_flag(8'hFF);
        send_idle = 84;
        run_phase(PHASE_ITEMS, 1'b0);

        write_flag(8'($urandom));
        send_idle = 0;
        stall_pct = 84;
        run_phase(PHASE_ITEMS, 1'b0);

        write_flag(8'($urandom));
        send_idle = 23;
        stall_pct = 23;
        run_phase(PHASE_ITEMS, 1'b0);

        write_flag(FLAG_BYTE_RESET);
        run_phase(PHASE_ITEMS, 1'b1);

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
